// File: src/console_line_editor_defines.svh
// Assertion macros shared by the console line editor checker.
// No dependencies; include once per file that asserts.
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// Property checked out of reset only.
`define CLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal must be low at the edge after any edge that saw reset asserted.
`define CLE_ASSERT_RESET_LOW(label, sig, msg) \
  label: assert property (@(posedge clk_i) !rst_ni |=> !(sig)) else $error(msg);

`endif

// File: src/cle_pkg.sv
// Package for the console line editor: key codes, key classes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package cle_pkg;

  localparam int unsigned LineDepth = 64;

  localparam logic [7:0] KeyBackspace = 8'h08;
  localparam logic [7:0] KeyNewline   = 8'h0A;
  localparam logic [7:0] KeyEof       = 8'h04;
  localparam logic [7:0] KeyKill      = 8'h15;

  typedef enum logic [2:0] {
    ClassPlain,
    ClassNewline,
    ClassBackspace,
    ClassKill,
    ClassEof
  } key_class_e;

  typedef struct packed {
    logic store;       // write key at fill index and advance
    logic fill_dec;    // drop last stored byte
    logic fill_clr;    // empty the line
    logic len_store;   // line ends on the byte being stored
    logic len_eof;     // line ends on end-of-file, nothing stored
    logic rd_en;       // issue a line store read
    logic out_raw;     // load output with the key byte
    logic out_empty;   // load output with the empty-line marker
    logic out_ram;     // load output with the line store read data
  } cmd_t;

  typedef struct packed {
    logic       raw;
    logic       fill_zero;
    logic       fill_last;
    logic       rd_last;
    logic       out_free;
    key_class_e key_class;
  } sts_t;

  function automatic key_class_e classify(input logic [7:0] key);
    key_class_e cls;
    priority if (key == KeyBackspace) cls = ClassBackspace;
    else if (key == KeyNewline) cls = ClassNewline;
    else if (key == KeyEof) cls = ClassEof;
    else if (key == KeyKill) cls = ClassKill;
    else cls = ClassPlain;
    return cls;
  endfunction

endpackage

`default_nettype wire

// File: src/cle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/cle_datapath.sv
// Datapath of the console line editor: mode register, fill and read indexes,
// line store and output register. Depends on cle_pkg and cle_ram.
`default_nettype none

module cle_datapath #(
  parameter int unsigned LINE_DEPTH = cle_pkg::LineDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic [7:0]    key_byte_i,
  input  wire logic          out_stall_i,
  input  wire cle_pkg::cmd_t cmd_i,
  output cle_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic               empty_line_o
);

  localparam int unsigned AddrW = $clog2(LINE_DEPTH);

  logic             raw_q;
  logic [AddrW-1:0] fill_q, fill_d;
  logic [AddrW-1:0] last_idx_q;
  logic [AddrW-1:0] rd_idx_q;
  logic             rd_last_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             last_q;
  logic             empty_q;
  logic [7:0]       rdata;

  cle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(fill_q),
    .wdata_i(key_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  always_comb begin
    fill_d = fill_q;
    priority if (cmd_i.fill_clr || cmd_i.len_store || cmd_i.len_eof) begin
      fill_d = '0;
    end else if (cmd_i.store) begin
      fill_d = fill_q + AddrW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - AddrW'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        raw_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      if (cmd_i.out_raw || cmd_i.out_empty || cmd_i.out_ram) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_store) begin
      last_idx_q <= fill_q;
      rd_idx_q   <= '0;
    end else if (cmd_i.len_eof) begin
      last_idx_q <= fill_q - AddrW'(1);
      rd_idx_q   <= '0;
    end else if (cmd_i.rd_en) begin
      rd_idx_q <= rd_idx_q + AddrW'(1);
    end
    if (cmd_i.rd_en) begin
      rd_last_q <= (rd_idx_q == last_idx_q);
    end
    if (cmd_i.out_raw) begin
      out_byte_q <= key_byte_i;
      last_q     <= 1'b1;
      empty_q    <= 1'b0;
    end else if (cmd_i.out_empty) begin
      out_byte_q <= 8'h00;
      last_q     <= 1'b1;
      empty_q    <= 1'b1;
    end else if (cmd_i.out_ram) begin
      out_byte_q <= rdata;
      last_q     <= rd_last_q;
      empty_q    <= 1'b0;
    end
  end

  always_comb begin
    sts_o.raw       = raw_q;
    sts_o.fill_zero = (fill_q == '0);
    sts_o.fill_last = (fill_q == AddrW'(LINE_DEPTH - 1));
    sts_o.rd_last   = rd_last_q;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    sts_o.key_class = cle_pkg::classify(key_byte_i);
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign last_o       = last_q;
  assign empty_line_o = empty_q;

endmodule

`default_nettype wire

// File: src/cle_controller.sv
// Controller of the console line editor: accepts key words, edits the line
// and sequences line delivery. Depends on cle_pkg.
`default_nettype none

module cle_controller (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire cle_pkg::sts_t sts_i,
  output logic               in_stall_o,
  output cle_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SEND
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    in_stall_o = (state_q != S_IDLE) || !sts_i.out_free;
    accept     = in_valid_i && !in_stall_o;
    cmd_o      = '0;
    state_d    = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.raw) begin
            cmd_o.out_raw = 1'b1;
          end else begin
            unique case (sts_i.key_class)
              cle_pkg::ClassBackspace: begin
                cmd_o.fill_dec = !sts_i.fill_zero;
              end
              cle_pkg::ClassKill: begin
                cmd_o.fill_clr = 1'b1;
              end
              cle_pkg::ClassEof: begin
                if (sts_i.fill_zero) begin
                  cmd_o.out_empty = 1'b1;
                end else begin
                  cmd_o.len_eof = 1'b1;
                  state_d       = S_FETCH;
                end
              end
              cle_pkg::ClassNewline: begin
                cmd_o.store     = 1'b1;
                cmd_o.len_store = 1'b1;
                state_d         = S_FETCH;
              end
              default: begin
                cmd_o.store = 1'b1;
                if (sts_i.fill_last) begin
                  cmd_o.len_store = 1'b1;
                  state_d         = S_FETCH;
                end
              end
            endcase
          end
        end
      end
      S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SEND;
      end
      S_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_ram = 1'b1;
          state_d       = sts_i.rd_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/console_line_editor.sv
// Console line editor, top level. Joins the controller and the datapath.
// Depends on cle_pkg, cle_controller, cle_datapath and cle_ram.
//
// Key words enter on in_valid_i/in_stall_o/key_byte_i; result words leave on
// out_valid_o/out_stall_i with out_byte_o, last_o and empty_line_o. The
// receiver of each channel drives stall; a word moves when valid is high and
// stall is low. raw_mode is written with cfg_we_i/cfg_wdata_i; the user must
// do so only while idle, as the block does not enforce it. In raw mode each key
// word appears in the output register the cycle after it is taken, with last
// set, and a key word is taken every cycle unless the receiver stalls a held
// word. In cooked mode editing keys give no result. A line ended by newline,
// end-of-file or a full store is read back from the line store byte by byte,
// S_FETCH reading and S_SEND loading the registered read data into the output
// register; input is stalled until the last byte is loaded. An empty line
// ended by end-of-file gives a single empty-line word the cycle after the key.
// Input is also stalled while the output register holds a word that the
// receiver stalls; held words never change. Reset empties the line, clears the
// output valid flag and selects cooked mode; the line store needs no clear.
`default_nettype none

module console_line_editor #(
  parameter int unsigned LINE_DEPTH = cle_pkg::LineDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] key_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] out_byte_o,
  output logic            last_o,
  output logic            empty_line_o
);

  cle_pkg::cmd_t cmd;
  cle_pkg::sts_t sts;

  cle_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  cle_datapath #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_byte_i  (key_byte_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .empty_line_o(empty_line_o)
  );

endmodule

`default_nettype wire

// File: src/cle_checker.sv
// Port-level checker for the console line editor, bound to the top level.
// Depends on console_line_editor_defines.svh.
`default_nettype none
`include "console_line_editor_defines.svh"

module cle_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_o,
  input wire logic       empty_line_o
);

  `CLE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o) && $stable(empty_line_o), "Stalled output word changed")

  `CLE_ASSERT(a_empty_form, out_valid_o && empty_line_o |-> last_o && (out_byte_o == 8'h00), "Empty-line word is malformed")

  `CLE_ASSERT(a_no_take_when_blocked, out_valid_o && out_stall_i |-> in_stall_o, "Key word taken while output is blocked")

  `CLE_ASSERT_RESET_LOW(a_reset_out, out_valid_o, "Output valid after reset")

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

`default_nettype wire

// File: tb/console_line_editor_checker.sv
// Checker for the console line editor: watches the mode write, the key channel and the
// result channel, predicts each result word and compares it with what the block delivers.
// Depends on cle_pkg for the line depth, the key codes and the key classes.
module console_line_editor_checker
  import cle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] key_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_i,
  input  logic       empty_line_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         words_checked_o,
  output int         eof_markers_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } word_t;

  word_t       expected_words[$];
  logic [7:0]  line_buf[LineDepth];
  int unsigned line_len;
  logic        raw_mode;

  function automatic key_class_e kind_of(input logic [7:0] code);
    case (code)
      KeyBackspace: return ClassBackspace;
      KeyNewline:   return ClassNewline;
      KeyEof:       return ClassEof;
      KeyKill:      return ClassKill;
      default:      return ClassPlain;
    endcase
  endfunction

  function automatic void edit_key(input logic [7:0] code);
    key_class_e  kind;
    logic        ends;
    int unsigned n;
    kind = kind_of(code);
    ends = 1'b0;
    if (raw_mode) begin
      expected_words.push_back('{data: code, last: 1'b1, empty: 1'b0});
      return;
    end
    case (kind)
      ClassBackspace: begin
        if (line_len != 0) line_len--;
        return;
      end
      ClassKill: begin
        line_len = 0;
        return;
      end
      ClassEof: ends = 1'b1;
      default: begin
        line_buf[line_len] = code;
        line_len++;
        ends = (kind == ClassNewline) || (line_len == LineDepth);
      end
    endcase
    if (!ends) return;
    n = line_len;
    line_len = 0;
    if (n == 0) begin
      expected_words.push_back('{data: 8'h00, last: 1'b1, empty: 1'b1});
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      expected_words.push_back('{data: line_buf[i], last: (i + 1 == n), empty: 1'b0});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t got;
    word_t want;
    if (!rst_ni) begin
      expected_words.delete();
      line_len = 0;
      raw_mode = 1'b0;
      fail_count_o = 0;
      pending_o = 0;
      words_checked_o = 0;
      eof_markers_o = 0;
    end else begin
      if (cfg_we_i) raw_mode = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) edit_key(key_byte_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{data: out_byte_i, last: last_i, empty: empty_line_i};
        words_checked_o++;
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected: out_byte %02h last %b empty_line %b",
                   $time, got.data, got.last, got.empty);
          fail_count_o++;
        end else begin
          want = expected_words.pop_front();
          if (got.data !== want.data)
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, got.data);
          if (got.last !== want.last)
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          if (got.empty !== want.empty)
            $display("%0t: empty_line expected %b actual %b", $time, want.empty, got.empty);
          if (got !== want) fail_count_o++;
          else if (want.empty) eof_markers_o++;
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// File: tb/tb_console_line_editor.sv
// Testbench top for the console line editor: drives keys and mode writes with bursty timing,
// stalls the result channel and gives the verdict from the checker's failure count.
// Depends on cle_pkg, console_line_editor_checker and the console_line_editor RTL.
module tb_console_line_editor;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int unsigned KeyTarget    = 450;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned SettleCycles = 16;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_style_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] key_byte_i  = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       empty_line_o;

  int fail_count;
  int pending;
  int words_checked;
  int eof_markers;

  int unsigned  keys_sent      = 0;
  int unsigned  keys_counted   = 0;
  int unsigned  mode_writes    = 0;
  int unsigned  burst_left     = 0;
  logic         cur_raw        = 1'b0;
  stall_style_e stall_style    = StallNone;
  int unsigned  stall_span     = 0;
  int unsigned  stall_phase    = 0;
  int unsigned  idle_cycles    = 0;

  console_line_editor i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_byte_i   (key_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .empty_line_o (empty_line_o)
  );

  console_line_editor_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .key_byte_i      (key_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .last_i          (last_o),
    .empty_line_i    (empty_line_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .eof_markers_o   (eof_markers)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 96);
    end
    stall_span--;
    stall_phase++;
    case (stall_style)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= ((stall_phase % 5) < 2);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_key(input logic [7:0] code);
    int unsigned gap;
    logic        stalled;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    key_byte_i <= code;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    keys_sent++;
    if (cur_raw || (code != KeyBackspace && code != KeyKill)) keys_counted++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_raw(input logic mode);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_raw = mode;
    mode_writes++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == KeyBackspace || b == KeyNewline || b == KeyEof || b == KeyKill);
    return b;
  endfunction

  // Mostly ordinary bytes with some editing keys; a few lines overrun the store, and
  // some are left unfinished so that a later mode change finds a partial line.
  task automatic cooked_line();
    int unsigned len;
    int unsigned r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 14);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) send_key(KeyBackspace);
      else if (r < 9) send_key(KeyKill);
      else send_key(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 99);
    if (r < 50) send_key(KeyNewline);
    else if (r < 85) send_key(KeyEof);
  endtask

  initial begin
    logic mode;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_raw(1'b0);
    send_key(KeyBackspace);
    send_key(KeyKill);
    send_key(KeyEof);
    send_key(KeyNewline);
    send_key(8'h00);
    send_key(8'hFF);
    send_key(KeyBackspace);
    send_key(8'h41);
    send_key(KeyNewline);
    send_key(8'h7E);
    send_key(8'h80);
    send_key(KeyKill);
    send_key(8'h55);
    send_key(KeyEof);
    send_key(8'h31);
    send_key(8'h32);
    set_raw(1'b1);
    send_key(KeyBackspace);
    send_key(KeyKill);
    send_key(KeyEof);
    send_key(KeyNewline);
    send_key(8'h00);
    send_key(8'hFF);
    set_raw(1'b0);
    send_key(KeyBackspace);
    send_key(8'h33);
    send_key(KeyNewline);

    repeat (LineDepth) send_key(plain_byte());
    while (keys_counted < KeyTarget) begin
      mode = ($urandom_range(0, 3) == 0);
      set_raw(mode);
      if (mode) begin
        repeat ($urandom_range(8, 40)) send_key(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 5)) cooked_line();
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    $display("Sent %0d key words over %0d mode writes, raw and cooked, with bursty timing.",
             keys_sent, mode_writes);
    $display("Checked %0d result words, %0d of them end-of-file markers.",
             words_checked, eof_markers);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/cle_pkg.sv
src/cle_ram.sv
src/cle_datapath.sv
src/cle_controller.sv
src/console_line_editor.sv
src/cle_checker.sv
tb/console_line_editor_checker.sv
tb/tb_console_line_editor.sv
